### sv/spi_epw_pkg.sv
package spi_epw_pkg;

    localparam int ADDR_BITS_DEF  = 12;
    localparam int PAGE_BYTES_DEF = 32;
    localparam int MAX_ADDR_BITS  = 16;
    localparam int QUEUE_DEPTH    = 2;
    localparam int NUM_STEPS      = 12;
    localparam int STEP_W         = 4;
    localparam int BYTE_W         = 8;
    localparam int CFG_INDEX_W    = 2;

    typedef enum logic [1:0] {
        ACT_LOW  = 2'd0,
        ACT_HIGH = 2'd1,
        ACT_SEND = 2'd2,
        ACT_WAIT = 2'd3
    } action_t;

    localparam logic [CFG_INDEX_W-1:0] REG_READ_CMD  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WRITE_CMD = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WREN_CMD  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DUMMY     = 2'd3;

    localparam logic [BYTE_W-1:0] RST_READ_CMD  = 8'h03;
    localparam logic [BYTE_W-1:0] RST_WRITE_CMD = 8'h02;
    localparam logic [BYTE_W-1:0] RST_WREN_CMD  = 8'h06;
    localparam logic [BYTE_W-1:0] RST_DUMMY     = 8'h00;

    // Script positions, sent in ascending order for each job.
    localparam logic [STEP_W-1:0] STEP_CLOSE_HIGH = 4'd0;
    localparam logic [STEP_W-1:0] STEP_CLOSE_WAIT = 4'd1;
    localparam logic [STEP_W-1:0] STEP_OPEN_LOW   = 4'd2;
    localparam logic [STEP_W-1:0] STEP_WREN       = 4'd3;
    localparam logic [STEP_W-1:0] STEP_WREN_HIGH  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_CMD_LOW    = 4'd5;
    localparam logic [STEP_W-1:0] STEP_CMD        = 4'd6;
    localparam logic [STEP_W-1:0] STEP_ADDR_HI    = 4'd7;
    localparam logic [STEP_W-1:0] STEP_ADDR_LO    = 4'd8;
    localparam logic [STEP_W-1:0] STEP_BODY       = 4'd9;
    localparam logic [STEP_W-1:0] STEP_TAIL_HIGH  = 4'd10;
    localparam logic [STEP_W-1:0] STEP_TAIL_WAIT  = 4'd11;

    typedef struct packed {
        logic [NUM_STEPS-1:0]     steps;
        logic                     is_write;
        logic                     drop;
        logic [MAX_ADDR_BITS-1:0] addr;
        logic [BYTE_W-1:0]        data;
    } job_t;

endpackage

### sv/spi_eeprom_page_write_sequencer_top.sv
// Page-write sequencer for a 25xx-style SPI EEPROM.
// Input channel (push/full): one beat asks to read or write one byte; first_byte
// and final_byte frame a transaction, start_address is taken on its first beat.
// Result channel (empty/pop): one beat per bus action, select low, select high,
// send byte or write wait, with capture, dropped and run_end flags; run_end
// marks the last action of an input beat.
// Configuration: cfg_write with cfg_index and cfg_data sets the read, write,
// write-enable and dummy bytes; write only while the block is idle.
// An input beat is classified in the cycle it is accepted and queued as a job.
// The job expander emits one action per cycle unless the result register is
// stalled, so an input beat yields one to twelve actions, usually one or two;
// its first action passes the job queue, the step register and the result
// register. Input is taken every cycle while the two-entry job queue has room.
// A stalled receiver holds the result register; the expander and then the job
// queue fill, after which full rises. Reset empties both sides, closes any
// transaction and restores the default command bytes.
module spi_eeprom_page_write_sequencer_top #(
    parameter int ADDR_BITS  = spi_epw_pkg::ADDR_BITS_DEF,
    parameter int PAGE_BYTES = spi_epw_pkg::PAGE_BYTES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic                                opcode,
    input  logic [ADDR_BITS-1:0]                start_address,
    input  logic [7:0]                          write_data,
    input  logic                                first_byte,
    input  logic                                final_byte,
    input  logic                                cfg_write,
    input  logic [spi_epw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                          cfg_data,
    output logic                                empty,
    input  logic                                pop,
    output logic [1:0]                          action,
    output logic [7:0]                          bus_byte,
    output logic                                capture,
    output logic                                dropped,
    output logic                                run_end
);

    spi_epw_pkg::job_t front_job, queue_job;
    logic              job_push, queue_full, queue_empty, job_pop;

    assign full = queue_full;

    spi_epw_front #(
        .ADDR_BITS  (ADDR_BITS),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .queue_full    (queue_full),
        .opcode        (opcode),
        .start_address (start_address),
        .write_data    (write_data),
        .first_byte    (first_byte),
        .final_byte    (final_byte),
        .job_push      (job_push),
        .job           (front_job)
    );

    spi_epw_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (job_push),
        .wr_job (front_job),
        .full   (queue_full),
        .rd_en  (job_pop),
        .rd_job (queue_job),
        .empty  (queue_empty)
    );

    spi_epw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .job_valid (!queue_empty),
        .job       (queue_job),
        .job_pop   (job_pop),
        .empty     (empty),
        .pop       (pop),
        .action    (action),
        .bus_byte  (bus_byte),
        .capture   (capture),
        .dropped   (dropped),
        .run_end   (run_end)
    );

endmodule

### sv/spi_epw_front.sv
module spi_epw_front #(
    parameter int ADDR_BITS  = spi_epw_pkg::ADDR_BITS_DEF,
    parameter int PAGE_BYTES = spi_epw_pkg::PAGE_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic                 queue_full,
    input  logic                 opcode,
    input  logic [ADDR_BITS-1:0] start_address,
    input  logic [7:0]           write_data,
    input  logic                 first_byte,
    input  logic                 final_byte,
    output logic                 job_push,
    output spi_epw_pkg::job_t    job
);

    localparam int PAGE_W = $clog2(PAGE_BYTES);

    logic                 in_trans_reg, in_trans_next;
    logic                 is_write_reg, is_write_next;
    logic                 past_end_reg, past_end_next;
    logic [ADDR_BITS:0]   next_addr_reg, next_addr_next;
    logic                 opened;

    assign job_push = push && !queue_full;

    always_comb
    begin
        job            = '0;
        in_trans_next  = in_trans_reg;
        is_write_next  = is_write_reg;
        next_addr_next = next_addr_reg;
        past_end_next  = past_end_reg;
        opened         = 1'b0;

        if (first_byte && in_trans_next)
        begin
            if (!past_end_next &&
                !(is_write_next && next_addr_next[PAGE_W-1:0] == '0))
            begin
                job.steps[spi_epw_pkg::STEP_CLOSE_HIGH] = 1'b1;
                job.steps[spi_epw_pkg::STEP_CLOSE_WAIT] = is_write_next;
            end
            in_trans_next = 1'b0;
        end

        if (!in_trans_next)
        begin
            in_trans_next  = 1'b1;
            is_write_next  = opcode;
            next_addr_next = {1'b0, start_address};
            past_end_next  = 1'b0;
            opened         = 1'b1;
            job.addr       = spi_epw_pkg::MAX_ADDR_BITS'(start_address);
            job.steps[spi_epw_pkg::STEP_OPEN_LOW]  = 1'b1;
            job.steps[spi_epw_pkg::STEP_WREN]      = opcode;
            job.steps[spi_epw_pkg::STEP_WREN_HIGH] = opcode;
            job.steps[spi_epw_pkg::STEP_CMD_LOW]   = opcode;
            job.steps[spi_epw_pkg::STEP_CMD]       = 1'b1;
            job.steps[spi_epw_pkg::STEP_ADDR_HI]   = 1'b1;
            job.steps[spi_epw_pkg::STEP_ADDR_LO]   = 1'b1;
        end

        job.is_write = is_write_next;
        job.data     = write_data;
        job.steps[spi_epw_pkg::STEP_BODY] = 1'b1;

        if (past_end_next)
        begin
            job.drop = 1'b1;
            if (final_byte)
            begin
                in_trans_next = 1'b0;
            end
        end
        else
        begin
            if (is_write_next && !opened && next_addr_next[PAGE_W-1:0] == '0)
            begin
                job.addr = spi_epw_pkg::MAX_ADDR_BITS'(next_addr_next[ADDR_BITS-1:0]);
                job.steps[spi_epw_pkg::STEP_OPEN_LOW]  = 1'b1;
                job.steps[spi_epw_pkg::STEP_WREN]      = 1'b1;
                job.steps[spi_epw_pkg::STEP_WREN_HIGH] = 1'b1;
                job.steps[spi_epw_pkg::STEP_CMD_LOW]   = 1'b1;
                job.steps[spi_epw_pkg::STEP_CMD]       = 1'b1;
                job.steps[spi_epw_pkg::STEP_ADDR_HI]   = 1'b1;
                job.steps[spi_epw_pkg::STEP_ADDR_LO]   = 1'b1;
            end
            next_addr_next = next_addr_next + 1'b1;
            if (final_byte || next_addr_next[ADDR_BITS])
            begin
                job.steps[spi_epw_pkg::STEP_TAIL_HIGH] = 1'b1;
                job.steps[spi_epw_pkg::STEP_TAIL_WAIT] = is_write_next;
                if (final_byte)
                begin
                    in_trans_next = 1'b0;
                end
                else
                begin
                    past_end_next = 1'b1;
                end
            end
            else if (is_write_next && next_addr_next[PAGE_W-1:0] == '0)
            begin
                job.steps[spi_epw_pkg::STEP_TAIL_HIGH] = 1'b1;
                job.steps[spi_epw_pkg::STEP_TAIL_WAIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_trans_reg  <= 1'b0;
            is_write_reg  <= 1'b0;
            past_end_reg  <= 1'b0;
            next_addr_reg <= '0;
        end
        else if (job_push)
        begin
            in_trans_reg  <= in_trans_next;
            is_write_reg  <= is_write_next;
            past_end_reg  <= past_end_next;
            next_addr_reg <= next_addr_next;
        end
    end

endmodule

### sv/spi_epw_queue.sv
module spi_epw_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  spi_epw_pkg::job_t wr_job,
    output logic              full,
    input  logic              rd_en,
    output spi_epw_pkg::job_t rd_job,
    output logic              empty
);

    localparam int DEPTH  = spi_epw_pkg::QUEUE_DEPTH;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    spi_epw_pkg::job_t  slots_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_wr, do_rd;

    assign full   = count_reg == CNT_W'(DEPTH);
    assign empty  = count_reg == '0;
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;
    assign rd_job = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots_reg[wr_ptr_reg] <= wr_job;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("job queue count exceeds its depth");
`endif

endmodule

### sv/spi_epw_back.sv
module spi_epw_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [spi_epw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                          cfg_data,
    input  logic                                job_valid,
    input  spi_epw_pkg::job_t                   job,
    output logic                                job_pop,
    output logic                                empty,
    input  logic                                pop,
    output logic [1:0]                          action,
    output logic [7:0]                          bus_byte,
    output logic                                capture,
    output logic                                dropped,
    output logic                                run_end
);

    localparam int NS = spi_epw_pkg::NUM_STEPS;

    logic [7:0]        read_cmd_reg, write_cmd_reg, wren_cmd_reg, dummy_reg;
    logic [NS-1:0]     steps_reg, steps_next;
    spi_epw_pkg::job_t cur_reg;
    logic              out_valid_reg;
    logic [1:0]        action_reg;
    logic [7:0]        bus_byte_reg;
    logic              capture_reg, dropped_reg, run_end_reg;

    logic [NS-1:0]                     low_bit;
    logic [NS-1:0]                     rest;
    logic [spi_epw_pkg::STEP_W-1:0]    step;
    logic                              advance;
    spi_epw_pkg::action_t              act_c;
    logic [7:0]                        byte_c;
    logic                              cap_c, drop_c;

    assign advance = (steps_reg != '0) && (!out_valid_reg || pop);
    assign low_bit = steps_reg & (~steps_reg + 1'b1);
    assign rest    = steps_reg & ~low_bit;
    assign job_pop = job_valid && ((steps_reg == '0) || (advance && rest == '0));

    always_comb
    begin
        step = '0;
        for (int i = NS - 1; i >= 0; i--)
        begin
            if (steps_reg[i])
            begin
                step = spi_epw_pkg::STEP_W'(i);
            end
        end
    end

    always_comb
    begin
        act_c  = spi_epw_pkg::ACT_HIGH;
        byte_c = '0;
        cap_c  = 1'b0;
        drop_c = 1'b0;
        unique case (step)
            spi_epw_pkg::STEP_CLOSE_HIGH,
            spi_epw_pkg::STEP_WREN_HIGH,
            spi_epw_pkg::STEP_TAIL_HIGH:
                act_c = spi_epw_pkg::ACT_HIGH;
            spi_epw_pkg::STEP_CLOSE_WAIT,
            spi_epw_pkg::STEP_TAIL_WAIT:
                act_c = spi_epw_pkg::ACT_WAIT;
            spi_epw_pkg::STEP_OPEN_LOW,
            spi_epw_pkg::STEP_CMD_LOW:
                act_c = spi_epw_pkg::ACT_LOW;
            spi_epw_pkg::STEP_WREN:
            begin
                act_c  = spi_epw_pkg::ACT_SEND;
                byte_c = wren_cmd_reg;
            end
            spi_epw_pkg::STEP_CMD:
            begin
                act_c  = spi_epw_pkg::ACT_SEND;
                byte_c = cur_reg.is_write ? write_cmd_reg : read_cmd_reg;
            end
            spi_epw_pkg::STEP_ADDR_HI:
            begin
                act_c  = spi_epw_pkg::ACT_SEND;
                byte_c = cur_reg.addr[15:8];
            end
            spi_epw_pkg::STEP_ADDR_LO:
            begin
                act_c  = spi_epw_pkg::ACT_SEND;
                byte_c = cur_reg.addr[7:0];
            end
            spi_epw_pkg::STEP_BODY:
            begin
                if (cur_reg.drop)
                begin
                    act_c  = spi_epw_pkg::ACT_HIGH;
                    drop_c = 1'b1;
                end
                else
                begin
                    act_c  = spi_epw_pkg::ACT_SEND;
                    byte_c = cur_reg.is_write ? cur_reg.data : dummy_reg;
                    cap_c  = !cur_reg.is_write;
                end
            end
            default:
                act_c = spi_epw_pkg::ACT_HIGH;
        endcase
    end

    always_comb
    begin
        steps_next = steps_reg;
        if (advance)
        begin
            steps_next = rest;
        end
        if (job_pop)
        begin
            steps_next = job.steps;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_cmd_reg  <= spi_epw_pkg::RST_READ_CMD;
            write_cmd_reg <= spi_epw_pkg::RST_WRITE_CMD;
            wren_cmd_reg  <= spi_epw_pkg::RST_WREN_CMD;
            dummy_reg     <= spi_epw_pkg::RST_DUMMY;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                spi_epw_pkg::REG_READ_CMD:  read_cmd_reg  <= cfg_data;
                spi_epw_pkg::REG_WRITE_CMD: write_cmd_reg <= cfg_data;
                spi_epw_pkg::REG_WREN_CMD:  wren_cmd_reg  <= cfg_data;
                spi_epw_pkg::REG_DUMMY:     dummy_reg     <= cfg_data;
                default:                    dummy_reg     <= dummy_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            steps_reg <= steps_next;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            cur_reg <= job;
        end
        if (advance)
        begin
            action_reg   <= act_c;
            bus_byte_reg <= byte_c;
            capture_reg  <= cap_c;
            dropped_reg  <= drop_c;
            run_end_reg  <= rest == '0;
        end
    end

    assign empty    = !out_valid_reg;
    assign action   = action_reg;
    assign bus_byte = bus_byte_reg;
    assign capture  = capture_reg;
    assign dropped  = dropped_reg;
    assign run_end  = run_end_reg;

`ifndef NO_ASSERTIONS
    a_capture_is_send: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && capture_reg |-> action_reg == spi_epw_pkg::ACT_SEND)
        else $error("capture marked on a beat that sends no byte");
    a_drop_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && dropped_reg |-> action_reg == spi_epw_pkg::ACT_HIGH && run_end_reg)
        else $error("dropped beat is not a lone select-high");
    a_job_has_steps: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> steps_reg != '0)
        else $error("loaded job carries no actions");
`endif

endmodule
